>>> hdl/tmp_pkg.sv
`default_nettype none
package tmp_pkg;

    localparam int NUM_CORES   = 16;
    localparam int TOP_DEPTH   = 4;
    localparam int TEMP_W      = 16;
    localparam int ID_W        = 6;
    localparam int CNT_W       = $clog2(NUM_CORES + 1);
    localparam int QCNT_W      = 2;

    localparam logic [TEMP_W-1:0] CRIT_RESET = 16'd10240;

    typedef struct packed {
        logic [TEMP_W-1:0] core_temp;
        logic              core_busy;
        logic              last_core;
    } in_item_t;

    typedef struct packed {
        logic            move_valid;
        logic [ID_W-1:0] source_core;
        logic [ID_W-1:0] target_core;
        logic            exchange;
        logic            run_end;
    } out_item_t;

    // one slot of the hottest-first list
    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [ID_W-1:0]   id;
        logic              busy;
    } entry_t;

    // list module -> proposer / top
    typedef struct packed {
        logic                        ends;    // current item closes the sweep
        logic                        enough;  // at least TOP_DEPTH cores incl. this one
        entry_t [TOP_DEPTH-1:0]      top;     // list after inserting the current item
    } sweep_t;

    // proposer -> result queue
    typedef struct packed {
        logic [QCNT_W-1:0] n;
        out_item_t [1:0]   res;
    } propose_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage
`default_nettype wire

>>> hdl/tmp_top_list.sv
`default_nettype none
module tmp_top_list (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire tmp_pkg::in_item_t item,
    output tmp_pkg::sweep_t        sweep
);

    tmp_pkg::entry_t [tmp_pkg::TOP_DEPTH-1:0] top_reg, top_next, top_ins;
    logic [tmp_pkg::CNT_W-1:0]                cnt_reg, cnt_next, cnt_inc;
    logic [tmp_pkg::TOP_DEPTH-1:0]            ins;
    tmp_pkg::entry_t                          new_e;
    logic                                     ends_w;

    always_comb begin
        new_e.temp = item.core_temp;
        new_e.id   = tmp_pkg::ID_W'(cnt_reg);
        new_e.busy = item.core_busy;

        // new item goes ahead of every filled slot that is strictly cooler
        for (int i = 0; i < tmp_pkg::TOP_DEPTH; i++) begin
            ins[i] = (cnt_reg <= tmp_pkg::CNT_W'(i)) || (top_reg[i].temp < item.core_temp);
        end

        for (int i = 0; i < tmp_pkg::TOP_DEPTH; i++) begin
            if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
                top_ins[i] = top_reg[(i > 0) ? i - 1 : 0];
            end else if (ins[i]) begin
                top_ins[i] = new_e;
            end else begin
                top_ins[i] = top_reg[i];
            end
        end

        cnt_inc = cnt_reg + tmp_pkg::CNT_W'(1);
        ends_w  = item.last_core || (cnt_inc == tmp_pkg::CNT_W'(tmp_pkg::NUM_CORES));

        sweep.ends   = ends_w;
        sweep.enough = (cnt_inc >= tmp_pkg::CNT_W'(tmp_pkg::TOP_DEPTH));
        sweep.top    = top_ins;

        top_next = top_reg;
        cnt_next = cnt_reg;
        if (accept) begin
            if (ends_w) begin
                top_next = '0;
                cnt_next = '0;
            end else begin
                top_next = top_ins;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg <= '0;
            cnt_reg <= '0;
        end else begin
            top_reg <= top_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/tmp_proposer.sv
`default_nettype none
module tmp_proposer (
    input  wire tmp_pkg::sweep_t              sweep,
    input  wire logic [tmp_pkg::TEMP_W-1:0]   critical_temp,
    output tmp_pkg::propose_t                 prop
);

    logic               fire;
    tmp_pkg::out_item_t r_a, r_b, r_none;

    always_comb begin
        fire = sweep.enough && (sweep.top[0].temp > critical_temp);

        // hottest -> fourth hottest
        r_a.move_valid  = 1'b1;
        r_a.source_core = sweep.top[0].id;
        r_a.target_core = sweep.top[3].id;
        r_a.exchange    = sweep.top[3].busy;
        r_a.run_end     = 1'b0;

        // second -> third hottest
        r_b.move_valid  = 1'b1;
        r_b.source_core = sweep.top[1].id;
        r_b.target_core = sweep.top[2].id;
        r_b.exchange    = sweep.top[2].busy;
        r_b.run_end     = 1'b0;

        r_none         = '0;
        r_none.run_end = 1'b1;

        prop.res = '0;
        case ({fire && sweep.top[0].busy, fire && sweep.top[1].busy})
            2'b11: begin
                prop.n              = 2'd2;
                prop.res[0]         = r_a;
                prop.res[1]         = r_b;
                prop.res[1].run_end = 1'b1;
            end
            2'b10: begin
                prop.n              = 2'd1;
                prop.res[0]         = r_a;
                prop.res[0].run_end = 1'b1;
            end
            2'b01: begin
                prop.n              = 2'd1;
                prop.res[0]         = r_b;
                prop.res[0].run_end = 1'b1;
            end
            default: begin
                prop.n      = 2'd1;
                prop.res[0] = r_none;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/tmp_result_queue.sv
`default_nettype none
module tmp_result_queue (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [tmp_pkg::QCNT_W-1:0] push_n,
    input  wire tmp_pkg::out_item_t [1:0]   push_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output tmp_pkg::out_item_t              m_data,
    output tmp_pkg::q_status_t              status
);

    tmp_pkg::out_item_t [1:0]   q_reg, q_next;
    logic [tmp_pkg::QCNT_W-1:0] cnt_reg, cnt_next, cnt_pop;
    logic                       pop;

    assign m_valid      = (cnt_reg != '0);
    assign m_data       = q_reg[0];
    assign status.count = cnt_reg;
    assign pop          = m_valid && m_ready;

    always_comb begin
        q_next  = q_reg;
        cnt_pop = cnt_reg - tmp_pkg::QCNT_W'(pop);
        if (pop) begin
            q_next[0] = q_reg[1];
        end
        // two-entry pushes only arrive when the queue drains empty
        case (push_n)
            2'd1: q_next[cnt_pop[0]] = push_data[0];
            2'd2: begin
                q_next[0] = push_data[0];
                q_next[1] = push_data[1];
            end
            default: ;
        endcase
        cnt_next = cnt_pop + push_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

endmodule
`default_nettype wire

>>> hdl/thermal_migration_picker.sv
`default_nettype none
// Channel  Direction  Ports                       Payload
// s_       in         s_valid s_ready s_data      tmp_pkg::in_item_t, one core per transaction
// m_       out        m_valid m_ready m_data      tmp_pkg::out_item_t, one proposal per transaction
// cfg_     in         cfg_valid cfg_ready cfg_data critical_temp, 16 bits
//
// Cycles: one core per cycle while s_ready is high. Insert into the four-entry list and
//   the proposal are one pass of logic; results land in a two-entry output queue.
// The sweep-closing transaction is taken only with the queue empty; its
//   one or two results then drain at one per cycle while m_ready is high.
// Reset (aresetn low, synchronous): list, core count and queue cleared,
//   critical_temp = 10240 (80 C).
// Mid-sweep cores keep flowing while results wait on m_ready.
module thermal_migration_picker (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire tmp_pkg::in_item_t        s_data,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output tmp_pkg::out_item_t            m_data,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [tmp_pkg::TEMP_W-1:0] cfg_data
);

    logic [tmp_pkg::TEMP_W-1:0] crit_reg;
    tmp_pkg::sweep_t            sweep;
    tmp_pkg::propose_t          prop;
    tmp_pkg::q_status_t         q_status;
    logic                       s_accept;
    logic                       end_accept;
    logic [tmp_pkg::QCNT_W-1:0] push_n;

    // threshold register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crit_reg <= tmp_pkg::CRIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            crit_reg <= cfg_data;
        end
    end

    // only the closing core needs queue room
    assign s_ready    = !sweep.ends || (q_status.count == '0);
    assign s_accept   = s_valid && s_ready;
    assign end_accept = s_accept && sweep.ends;
    assign push_n     = end_accept ? prop.n : '0;

    tmp_top_list u_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .item    (s_data),
        .sweep   (sweep)
    );

    tmp_proposer u_prop (
        .sweep         (sweep),
        .critical_temp (crit_reg),
        .prop          (prop)
    );

    tmp_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push_data (prop.res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .status    (q_status)
    );

    // queue never holds more than two results
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= 2'd2)
        else $error("result queue overflow");

    // a closed sweep always yields a result next cycle
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        end_accept |=> m_valid)
        else $error("sweep closed without result");

    // the no-proposal result has zero cores and no exchange, and ends the sweep
    a_invalid_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.move_valid) |->
            (m_data.run_end && m_data.source_core == '0 &&
             m_data.target_core == '0 && !m_data.exchange))
        else $error("malformed invalid result");

    // input stalls only while results are pending
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty queue");

endmodule
`default_nettype wire
